// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the ray/box hit test RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RBH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define RBH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rbh_pkg.sv =====
// Package for the ray/box hit test: default widths, queue status type and
// the bit layout of a classified word. No dependencies.
package rbh_pkg;

    localparam int unsigned FRAC_BITS_DEF = 16;
    localparam int unsigned WORD_BITS_DEF = 32;
    localparam int unsigned QUEUE_DEPTH   = 4;
    localparam int unsigned NUM_AXES      = 3;
    localparam int unsigned NUM_PLANES    = 6;

    // Queue status seen by both sides
    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

    // Classified word layout, w = word width:
    // lo[3] (w), hi[3] (w+1), org[3] (w), dir[3] (w), |dir|[3] (w),
    // |num|[6] (w+1), clamp[6] (1)
    function automatic int unsigned off_lo(int unsigned w);
        return 0;
    endfunction

    function automatic int unsigned off_hi(int unsigned w);
        return 3 * w;
    endfunction

    function automatic int unsigned off_org(int unsigned w);
        return 6 * w + 3;
    endfunction

    function automatic int unsigned off_dir(int unsigned w);
        return 9 * w + 3;
    endfunction

    function automatic int unsigned off_adir(int unsigned w);
        return 12 * w + 3;
    endfunction

    function automatic int unsigned off_anum(int unsigned w);
        return 15 * w + 3;
    endfunction

    function automatic int unsigned off_clamp(int unsigned w);
        return 21 * w + 9;
    endfunction

    function automatic int unsigned item_bits(int unsigned w);
        return 21 * w + 15;
    endfunction

endpackage

// ===== rtl/rbh_front.sv =====
// Front end: accepts a box/ray word, forms box bounds, then classifies the
// six planes (offset magnitude, clamp) on the way into the queue. Uses rbh_pkg.
module rbh_front #(
    parameter int unsigned WORD_BITS = rbh_pkg::WORD_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic [WORD_BITS-1:0]                      box_x,
    input  logic [WORD_BITS-1:0]                      box_y,
    input  logic [WORD_BITS-1:0]                      box_z,
    input  logic [WORD_BITS-2:0]                      box_width,
    input  logic [WORD_BITS-2:0]                      box_height,
    input  logic [WORD_BITS-2:0]                      box_depth,
    input  logic [WORD_BITS-1:0]                      origin_x,
    input  logic [WORD_BITS-1:0]                      origin_y,
    input  logic [WORD_BITS-1:0]                      origin_z,
    input  logic [WORD_BITS-1:0]                      dir_x,
    input  logic [WORD_BITS-1:0]                      dir_y,
    input  logic [WORD_BITS-1:0]                      dir_z,
    input  rbh_pkg::q_status_t                        q_status,
    output logic                                      push,
    output logic [rbh_pkg::item_bits(WORD_BITS)-1:0]  word
);
    import rbh_pkg::*;

    localparam int unsigned W  = WORD_BITS;

    localparam int unsigned OFF_LO    = off_lo(W);
    localparam int unsigned OFF_HI    = off_hi(W);
    localparam int unsigned OFF_ORG   = off_org(W);
    localparam int unsigned OFF_DIR   = off_dir(W);
    localparam int unsigned OFF_ADIR  = off_adir(W);
    localparam int unsigned OFF_ANUM  = off_anum(W);
    localparam int unsigned OFF_CLAMP = off_clamp(W);

    logic           accept;
    logic           fvld_reg;
    logic           fvld_next;
    logic [W-1:0]   lo_reg  [NUM_AXES];
    logic [W:0]     hi_reg  [NUM_AXES];
    logic [W-1:0]   org_reg [NUM_AXES];
    logic [W-1:0]   dir_reg [NUM_AXES];
    logic [W-1:0]   adir_w  [NUM_AXES];
    logic [W:0]     anum_w  [NUM_PLANES];
    logic           clamp_w [NUM_PLANES];

    // Handshake: hold the word while the queue is full
    assign in_stall  = fvld_reg && q_status.full;
    assign accept    = in_valid && !in_stall;
    assign push      = fvld_reg && !q_status.full;
    assign fvld_next = accept || (fvld_reg && q_status.full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fvld_reg <= 1'b0;
        end
        else
        begin
            fvld_reg <= fvld_next;
        end
    end

    // Box bounds and ray capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lo_reg[0]  <= box_x;
            lo_reg[1]  <= box_y;
            lo_reg[2]  <= box_z;
            hi_reg[0]  <= {box_x[W-1], box_x} + {2'b00, box_width};
            hi_reg[1]  <= {box_y[W-1], box_y} + {2'b00, box_height};
            hi_reg[2]  <= {box_z[W-1], box_z} + {2'b00, box_depth};
            org_reg[0] <= origin_x;
            org_reg[1] <= origin_y;
            org_reg[2] <= origin_z;
            dir_reg[0] <= dir_x;
            dir_reg[1] <= dir_y;
            dir_reg[2] <= dir_z;
        end
    end

    // Direction magnitudes
    for (genvar k = 0; k < NUM_AXES; k++)
    begin : g_adir
        assign adir_w[k] = dir_reg[k][W-1] ? (W'(0) - dir_reg[k]) : dir_reg[k];
    end

    // Plane offsets: both differences in parallel, pick the positive one
    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_plane
        localparam int unsigned K = p / 2;
        logic [W:0]   plane;
        logic [W+1:0] pl_x;
        logic [W+1:0] og_x;
        logic [W+1:0] dif;
        logic [W+1:0] rdif;
        logic         neg;

        assign plane = ((p % 2) == 0) ? {lo_reg[K][W-1], lo_reg[K]} : hi_reg[K];
        assign pl_x  = {plane[W], plane};
        assign og_x  = {{2{org_reg[K][W-1]}}, org_reg[K]};
        assign dif   = pl_x - og_x;
        assign rdif  = og_x - pl_x;
        assign neg   = dif[W+1];
        assign anum_w[p]  = neg ? rdif[W:0] : dif[W:0];
        // plane behind the ray: length goes negative, point stays at origin
        assign clamp_w[p] = (dif != '0) && (neg != dir_reg[K][W-1]);
    end

    // Pack the classified word
    always_comb
    begin
        word = '0;
        for (int k = 0; k < NUM_AXES; k++)
        begin
            word[OFF_LO   + k*W     +: W]   = lo_reg[k];
            word[OFF_HI   + k*(W+1) +: W+1] = hi_reg[k];
            word[OFF_ORG  + k*W     +: W]   = org_reg[k];
            word[OFF_DIR  + k*W     +: W]   = dir_reg[k];
            word[OFF_ADIR + k*W     +: W]   = adir_w[k];
        end
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            word[OFF_ANUM + p*(W+1) +: W+1] = anum_w[p];
            word[OFF_CLAMP + p]             = clamp_w[p];
        end
    end

endmodule

// ===== rtl/rbh_queue.sv =====
// Short flop queue between front and back; DEPTH must be a power of two.
// Uses rbh_pkg and assert_macros.svh.
module rbh_queue #(
    parameter int unsigned WIDTH = rbh_pkg::item_bits(rbh_pkg::WORD_BITS_DEF),
    parameter int unsigned DEPTH = rbh_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [WIDTH-1:0]   wr_data,
    input  logic               pop,
    output logic [WIDTH-1:0]   rd_data,
    output rbh_pkg::q_status_t q_status
);
    import rbh_pkg::*;
    `include "assert_macros.svh"

    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic [CNTW-1:0]  cnt_next;

    assign q_status.not_empty = (cnt_reg != '0);
    assign q_status.full      = (cnt_reg == CNTW'(DEPTH));
    assign rd_data            = mem_reg[rd_ptr_reg];

    // Fill count
    always_comb
    begin
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `RBH_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !q_status.full, "queue written while full")
    `RBH_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, q_status.not_empty, "queue read while empty")
    `RBH_ASSERT_NXT(a_fill, clk, rst_n, push && !pop, q_status.not_empty, "queue lost a word")

endmodule

// ===== rtl/rbh_back.sv =====
// Back end: per-plane pipelined restoring dividers (one quotient bit a stage),
// then scaled products, plane points and box test. Uses rbh_pkg.
module rbh_back #(
    parameter int unsigned FRAC_BITS = rbh_pkg::FRAC_BITS_DEF,
    parameter int unsigned WORD_BITS = rbh_pkg::WORD_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  rbh_pkg::q_status_t                        q_status,
    input  logic [rbh_pkg::item_bits(WORD_BITS)-1:0]  q_word,
    output logic                                      pop,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic                                      hit
);
    import rbh_pkg::*;

    localparam int unsigned W  = WORD_BITS;
    localparam int unsigned F  = FRAC_BITS;
    localparam int unsigned IW = item_bits(W);
    localparam int unsigned HW = F + 1;
    localparam int unsigned CW = (HW > W) ? HW : W;
    localparam int unsigned PW = 2 * W - 1;
    localparam int unsigned MW = PW - F;

    localparam int unsigned OFF_LO    = off_lo(W);
    localparam int unsigned OFF_HI    = off_hi(W);
    localparam int unsigned OFF_ORG   = off_org(W);
    localparam int unsigned OFF_DIR   = off_dir(W);
    localparam int unsigned OFF_ADIR  = off_adir(W);
    localparam int unsigned OFF_ANUM  = off_anum(W);
    localparam int unsigned OFF_CLAMP = off_clamp(W);

    localparam logic [W-2:0] LEN_MAX = {(W-1){1'b1}};

    logic                adv;
    logic [W:0]          vld_reg;
    logic [IW-1:0]       item_reg [W+1];
    logic [W-1:0]        rem_reg  [W+1][NUM_PLANES];
    logic [W-1:0]        quo_reg  [W+1][NUM_PLANES];
    logic                ovf_reg  [W+1][NUM_PLANES];

    logic                mvld_reg;
    logic [IW-1:0]       mitem_reg;
    logic [PW-1:0]       prod_reg [NUM_PLANES][NUM_AXES];
    logic                ovr_reg  [NUM_PLANES];

    logic                pvld_reg;
    logic [IW-1:0]       pitem_reg;
    logic signed [W:0]   pt_reg   [NUM_PLANES][NUM_AXES];
    logic                use_reg  [NUM_PLANES];

    logic [NUM_PLANES-1:0] in_box;
    logic                out_valid_reg;
    logic                hit_reg;
    logic                hit_next;

    // Whole back pipeline moves unless the output word is held
    assign adv       = !(out_valid_reg && out_stall);
    assign pop       = adv && q_status.not_empty;
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            mvld_reg      <= 1'b0;
            pvld_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[W-1:0], pop};
            mvld_reg      <= vld_reg[W];
            pvld_reg      <= mvld_reg;
            out_valid_reg <= pvld_reg;
        end
    end

    // Stage 0: quotient overflow check and remainder seed
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg[0] <= q_word;
        end
    end

    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_seed
        localparam int unsigned K = p / 2;
        logic [W:0]    anum;
        logic [W-1:0]  adir;
        logic [HW-1:0] high;

        assign anum = q_word[OFF_ANUM + p*(W+1) +: W+1];
        assign adir = q_word[OFF_ADIR + K*W +: W];
        // dividend is anum << F; its bits above W
        assign high = anum[W -: HW];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[0][p] <= W'(CW'(high));
                quo_reg[0][p] <= '0;
                ovf_reg[0][p] <= (CW'(high) >= CW'(adir));
            end
        end
    end

    // Divider stages: one quotient bit each, MSB first
    for (genvar j = 1; j <= W; j++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                item_reg[j] <= item_reg[j-1];
            end
        end

        for (genvar p = 0; p < NUM_PLANES; p++)
        begin : g_pl
            localparam int unsigned K = p / 2;
            logic [W:0]     anum;
            logic [W-1:0]   adir;
            logic [W+F:0]   dvd;
            logic [W:0]     rs;
            logic [W:0]     diff;
            logic           ge;

            assign anum = item_reg[j-1][OFF_ANUM + p*(W+1) +: W+1];
            assign adir = item_reg[j-1][OFF_ADIR + K*W +: W];
            assign dvd  = {anum, {F{1'b0}}};
            assign rs   = {rem_reg[j-1][p], dvd[W-j]};
            assign diff = rs - {1'b0, adir};
            assign ge   = (rs >= {1'b0, adir});

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[j][p] <= ge ? diff[W-1:0] : rs[W-1:0];
                    quo_reg[j][p] <= {quo_reg[j-1][p][W-2:0], ge};
                    ovf_reg[j][p] <= ovf_reg[j-1][p];
                end
            end
        end
    end

    // Multiply stage: saturate/clamp the length, scale each axis
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mitem_reg <= item_reg[W];
        end
    end

    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_mul
        logic         clamp;
        logic         sat;
        logic [W-2:0] len;

        assign clamp = item_reg[W][OFF_CLAMP + p];
        assign sat   = ovf_reg[W][p] || quo_reg[W][p][W-1];
        assign len   = clamp ? '0 : (sat ? LEN_MAX : quo_reg[W][p][W-2:0]);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ovr_reg[p] <= !sat && !clamp;
            end
        end

        for (genvar i = 0; i < NUM_AXES; i++)
        begin : g_ax
            logic [W-1:0] adir;

            assign adir = item_reg[W][OFF_ADIR + i*W +: W];

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    prod_reg[p][i] <= PW'(len) * PW'(adir);
                end
            end
        end
    end

    // Point stage: drop fraction, saturate, apply sign, snap own axis
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pitem_reg <= mitem_reg;
        end
    end

    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_pt
        localparam int unsigned K = p / 2;
        logic [W-1:0]      dir_k;
        logic signed [W:0] plane;

        assign dir_k = mitem_reg[OFF_DIR + K*W +: W];
        assign plane = ((p % 2) == 0)
                     ? {mitem_reg[OFF_LO + K*W + W - 1], mitem_reg[OFF_LO + K*W +: W]}
                     : mitem_reg[OFF_HI + K*(W+1) +: W+1];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                use_reg[p] <= (dir_k != '0);
            end
        end

        for (genvar i = 0; i < NUM_AXES; i++)
        begin : g_ax
            logic [MW-1:0]     m_full;
            logic [W-2:0]      m;
            logic [W-1:0]      org;
            logic              dneg;
            logic signed [W:0] org_x;
            logic signed [W:0] sm;
            logic signed [W:0] val;

            assign m_full = prod_reg[p][i][PW-1:F];
            assign m      = (m_full > MW'(LEN_MAX)) ? LEN_MAX : m_full[W-2:0];
            assign org    = mitem_reg[OFF_ORG + i*W +: W];
            assign dneg   = mitem_reg[OFF_DIR + i*W + W - 1];
            assign org_x  = {org[W-1], org};
            assign sm     = {2'b00, m};

            always_comb
            begin
                if ((i == K) && ovr_reg[p])
                begin
                    val = plane;
                end
                else if (dneg)
                begin
                    val = org_x - sm;
                end
                else
                begin
                    val = org_x + sm;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    pt_reg[p][i] <= val;
                end
            end
        end
    end

    // Box test: inclusive bounds on all three axes
    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_box
        logic [NUM_AXES-1:0] ok;

        for (genvar i = 0; i < NUM_AXES; i++)
        begin : g_ax
            logic signed [W:0] lo_x;
            logic signed [W:0] hi_x;

            assign lo_x  = {pitem_reg[OFF_LO + i*W + W - 1], pitem_reg[OFF_LO + i*W +: W]};
            assign hi_x  = pitem_reg[OFF_HI + i*(W+1) +: W+1];
            assign ok[i] = (pt_reg[p][i] >= lo_x) && (pt_reg[p][i] <= hi_x);
        end

        assign in_box[p] = use_reg[p] && (&ok);
    end

    assign hit_next = |in_box;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg <= hit_next;
        end
    end

endmodule

// ===== rtl/ray_box_hit_test_core.sv =====
// Ray versus axis-aligned box hit test.
//
// Input channel: in_valid / in_stall carry one word: box minimum corner,
// three extents, ray origin and direction, all signed fixed point with
// FRAC_BITS fraction bits (extents unsigned). A word is taken on a rising
// edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry one word per input word, the
// hit flag, in input order.
// Throughput: one word per cycle while neither channel stalls. A word passes
// the front register, the queue, a seed stage, the per-plane pipelined
// dividers (one quotient bit per stage), then multiply, point and hit.
// A stalled output holds the whole back pipeline; the 4-word queue behind the
// front end keeps accepting until it fills, then in_stall rises.
// Reset (rst_n low, asynchronous) empties the pipeline and queue; no other
// state exists and no clearing pass is needed.
// Depends on rbh_pkg, rbh_front, rbh_queue and rbh_back.
module ray_box_hit_test_core #(
    parameter int unsigned FRAC_BITS = rbh_pkg::FRAC_BITS_DEF,
    parameter int unsigned WORD_BITS = rbh_pkg::WORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [WORD_BITS-1:0] box_x,
    input  logic [WORD_BITS-1:0] box_y,
    input  logic [WORD_BITS-1:0] box_z,
    input  logic [WORD_BITS-2:0] box_width,
    input  logic [WORD_BITS-2:0] box_height,
    input  logic [WORD_BITS-2:0] box_depth,
    input  logic [WORD_BITS-1:0] origin_x,
    input  logic [WORD_BITS-1:0] origin_y,
    input  logic [WORD_BITS-1:0] origin_z,
    input  logic [WORD_BITS-1:0] dir_x,
    input  logic [WORD_BITS-1:0] dir_y,
    input  logic [WORD_BITS-1:0] dir_z,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 hit
);
    import rbh_pkg::*;

    localparam int unsigned IW = item_bits(WORD_BITS);

    q_status_t     q_status;
    logic          push;
    logic          pop;
    logic [IW-1:0] wr_word;
    logic [IW-1:0] rd_word;

    // Front end: capture and classify
    rbh_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .box_x      (box_x),
        .box_y      (box_y),
        .box_z      (box_z),
        .box_width  (box_width),
        .box_height (box_height),
        .box_depth  (box_depth),
        .origin_x   (origin_x),
        .origin_y   (origin_y),
        .origin_z   (origin_z),
        .dir_x      (dir_x),
        .dir_y      (dir_y),
        .dir_z      (dir_z),
        .q_status   (q_status),
        .push       (push),
        .word       (wr_word)
    );

    // Decoupling queue
    rbh_queue #(
        .WIDTH (IW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_data  (wr_word),
        .pop      (pop),
        .rd_data  (rd_word),
        .q_status (q_status)
    );

    // Back end: divide, scale, test
    rbh_back #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_word    (rd_word),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hit       (hit)
    );

endmodule
